[src/pixel_frame_code_decoder_assert.svh]
// Assertion macros shared by the frame code decoder modules.
// No dependencies; each using module includes this file after its ports.
`ifndef PIXEL_FRAME_CODE_DECODER_ASSERT_SVH
`define PIXEL_FRAME_CODE_DECODER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define PFCD_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("frame code decoder: invariant violated");

// When the first condition holds, the second holds in the cycle after.
`define PFCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame code decoder: sequence violated");

`endif

[src/pfcd_pkg.sv]
// Shared types and constants of the pixel frame code decoder.
// No dependencies; imported by every module of the block.
package pfcd_pkg;

   localparam int CFG_DATA_BITS = 12;
   localparam int CODE_BITS     = 24;
   localparam int VALUE_BITS    = 16;

   localparam int CODE_ROW   = 12;
   localparam int CODE_COL   = 12;
   localparam int MIN_WIDTH  = 248;
   localparam int MIN_HEIGHT = 16;
   localparam int WIDTH_RESET  = 1920;
   localparam int HEIGHT_RESET = 1080;

   localparam logic [3:0] PHASE_LAST = 4'd9;
   localparam logic [4:0] CELL_COUNT = 5'd24;
   localparam logic [9:0] BIT_LEVEL  = 10'd384;
   localparam logic [3:0] PREAMBLE   = 4'b1010;

   typedef enum logic [0:0] {
      CFG_FRAME_WIDTH  = 1'b0,
      CFG_FRAME_HEIGHT = 1'b1
   } cfg_reg_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SMALL    = 2'd1,
      STATUS_PREAMBLE = 2'd2,
      STATUS_PARITY   = 2'd3
   } status_type;

   typedef struct packed {
      logic                  too_small;
      logic [CODE_BITS-1:0]  code_bits;
   } frame_event_type;

endpackage

[src/pfcd_tracker.sv]
// Pixel position tracking, cell sampling and frame end capture.
// Depends on pfcd_pkg and the assertion macro header.
module pfcd_tracker import pfcd_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [0:0]               csr_index,
   input  logic [CFG_DATA_BITS-1:0] csr_wdata,
   input  logic                     pix_valid,
   output logic                     pix_ready,
   input  logic [7:0]               red,
   input  logic [7:0]               green,
   input  logic [7:0]               blue,
   input  logic                     start_of_frame,
   output logic                     ev_valid,
   output frame_event_type          ev_data,
   input  logic                     ev_take
);

   `include "pixel_frame_code_decoder_assert.svh"

   logic [COORD_BITS-1:0] width_ff, width_in, height_ff, height_in;
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;
   logic [3:0]            phase_ff, phase_in;
   logic [4:0]            idx_ff, idx_in;
   logic                  ev_valid_ff, ev_valid_in;
   frame_event_type       ev_data_ff, ev_data_in;

   logic                  accept, in_code, take_cell, sample_bit, frame_end;
   logic [9:0]            sum;
   logic [COORD_BITS-1:0] col_c, row_c, last_col, last_row;
   logic [CODE_BITS-1:0]  code_c, code_n;
   logic [3:0]            phase_c, phase_n;
   logic [4:0]            idx_c, idx_n;

   assign pix_ready = !ev_valid_ff || ev_take;
   assign accept    = pix_valid && pix_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         if (csr_index == CFG_FRAME_WIDTH) begin
            width_in = COORD_BITS'(csr_wdata);
         end else begin
            height_in = COORD_BITS'(csr_wdata);
         end
      end
   end

   always_comb begin
      sum        = 10'(red) + 10'(green) + 10'(blue);
      sample_bit = (sum >= BIT_LEVEL);
      col_c      = start_of_frame ? '0 : col_ff;
      row_c      = start_of_frame ? '0 : row_ff;
      code_c     = start_of_frame ? '0 : code_ff;
      phase_c    = start_of_frame ? '0 : phase_ff;
      idx_c      = start_of_frame ? '0 : idx_ff;
      last_col   = width_ff - COORD_BITS'(1);
      last_row   = height_ff - COORD_BITS'(1);

      in_code    = (row_c == COORD_BITS'(CODE_ROW)) && (col_c >= COORD_BITS'(CODE_COL));
      take_cell  = in_code && (phase_c == 4'd0) && (idx_c < CELL_COUNT);
      code_n     = take_cell ? {code_c[CODE_BITS-2:0], sample_bit} : code_c;
      idx_n      = take_cell ? idx_c + 5'd1 : idx_c;
      phase_n    = phase_c;
      if (in_code) begin
         phase_n = (phase_c == PHASE_LAST) ? 4'd0 : phase_c + 4'd1;
      end

      frame_end = 1'b0;
      col_in    = col_c + COORD_BITS'(1);
      row_in    = row_c;
      code_in   = code_n;
      phase_in  = phase_n;
      idx_in    = idx_n;
      if (col_c == last_col) begin
         col_in   = '0;
         phase_in = '0;
         idx_in   = '0;
         if (row_c == last_row) begin
            frame_end = 1'b1;
            row_in    = '0;
            code_in   = '0;
         end else begin
            row_in = row_c + COORD_BITS'(1);
         end
      end

      ev_data_in.too_small = (width_ff < COORD_BITS'(MIN_WIDTH)) ||
                             (height_ff < COORD_BITS'(MIN_HEIGHT));
      ev_data_in.code_bits = code_n;
      ev_valid_in = (ev_valid_ff && !ev_take) || (accept && frame_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= COORD_BITS'(WIDTH_RESET);
         height_ff   <= COORD_BITS'(HEIGHT_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         code_ff     <= '0;
         phase_ff    <= '0;
         idx_ff      <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         ev_valid_ff <= ev_valid_in;
         if (accept) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            code_ff  <= code_in;
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_end) begin
         ev_data_ff <= ev_data_in;
      end
   end

   assign ev_valid = ev_valid_ff;
   assign ev_data  = ev_data_ff;

   `PFCD_ASSERT_HOLDS(a_idx_range, clock, reset, idx_ff <= CELL_COUNT)
   `PFCD_ASSERT_HOLDS(a_phase_range, clock, reset, phase_ff <= PHASE_LAST)
   `PFCD_ASSERT_NEXT(a_frame_end_clears, clock, reset, accept && frame_end,
      col_ff == '0 && row_ff == '0 && code_ff == '0 && ev_valid_ff)

endmodule

[src/pfcd_checker.sv]
// Code checks and the registered result stage of the frame code decoder.
// Depends on pfcd_pkg and the assertion macro header.
module pfcd_checker import pfcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ev_valid,
   input  frame_event_type       ev_data,
   output logic                  ev_take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            status,
   output logic                  code_valid,
   output logic [VALUE_BITS-1:0] frame_value
);

   `include "pixel_frame_code_decoder_assert.svh"

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [VALUE_BITS-1:0] v;
   logic [3:0]            parity_bad;

   assign ev_take = ev_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      v = ev_data.code_bits[VALUE_BITS+3:4];
      for (int g = 0; g < 4; g++) begin
         parity_bad[g] = v[15-g] ^ v[11-g] ^ v[7-g] ^ v[3-g] ^ ev_data.code_bits[3-g];
      end
      status_in = STATUS_OK;
      value_in  = '0;
      if (ev_data.too_small) begin
         status_in = STATUS_SMALL;
      end else if (ev_data.code_bits[CODE_BITS-1:CODE_BITS-4] != PREAMBLE) begin
         status_in = STATUS_PREAMBLE;
      end else if (parity_bad != 4'b0000) begin
         status_in = STATUS_PARITY;
      end else begin
         value_in = v;
      end
      rsp_valid_in = ev_take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_take) begin
         status_ff <= status_in;
         value_ff  <= value_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign status      = status_ff;
   assign code_valid  = (status_ff == STATUS_OK);
   assign frame_value = value_ff;

   `PFCD_ASSERT_NEXT(a_take_loads, clock, reset, ev_take, rsp_valid_ff)
   `PFCD_ASSERT_HOLDS(a_zero_on_fail, clock, reset,
      !rsp_valid_ff || status_ff == STATUS_OK || value_ff == '0)
   `PFCD_ASSERT_HOLDS(a_take_needs_room, clock, reset,
      !ev_take || !rsp_valid_ff || rsp_ready)

endmodule

[src/pixel_frame_code_decoder.sv]
// Top level of the pixel frame code decoder.
// Depends on pfcd_pkg, pfcd_tracker and pfcd_checker.
//
// The block takes one pixel item per clock in raster order and returns one result item per
// frame once the last pixel is accepted: the sampling and position counters update as a
// pixel is taken, the frame code is captured in an event register and checked once the
// output register has room, and the result waits in that output register. A pixel is held
// back only while both the captured frame code and the previous result are still waiting
// to be taken, so a stalled result costs nothing until the next frame ends.
module pixel_frame_code_decoder import pfcd_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [0:0]               csr_index,
   input  logic [CFG_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [23:0]              req_tdata,   // red, green, blue
   input  logic                     req_tuser,   // start_of_frame
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // frame_value
   output logic [2:0]               rsp_tuser    // status, code_valid
);

   logic            ev_valid, ev_take;
   frame_event_type ev_data;
   logic [1:0]      status;
   logic            code_valid;

   pfcd_tracker #(
      .COORD_BITS (COORD_BITS)
   ) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pix_valid      (req_tvalid),
      .pix_ready      (req_tready),
      .red            (req_tdata[7:0]),
      .green          (req_tdata[15:8]),
      .blue           (req_tdata[23:16]),
      .start_of_frame (req_tuser),
      .ev_valid       (ev_valid),
      .ev_data        (ev_data),
      .ev_take        (ev_take)
   );

   pfcd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .ev_valid    (ev_valid),
      .ev_data     (ev_data),
      .ev_take     (ev_take),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .status      (status),
      .code_valid  (code_valid),
      .frame_value (rsp_tdata)
   );

   assign rsp_tuser = {code_valid, status};

endmodule
